// ----- rtl/core/blpr_pkg.sv -----
// Brake light PID ramp: shared types and constants.
// Used by every module in rtl/core; depends on nothing.
package blpr_pkg;

    localparam logic [10:0] BRIGHT_FULL = 11'd1279;
    localparam logic [10:0] BRIGHT_MID  = 11'd463;
    localparam logic [10:0] BRIGHT_IDLE = 11'd79;

    localparam int ACC_W = 50;  // widest sum of the three gain products

    typedef enum logic [2:0] {
        CFG_P_GAIN    = 3'd0,
        CFG_I_GAIN    = 3'd1,
        CFG_D_GAIN    = 3'd2,
        CFG_WINDUP    = 3'd3,
        CFG_BRAKE_TH  = 3'd4,
        CFG_ACCEL_TH  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] p_gain;
        logic [15:0] i_gain;
        logic [15:0] d_gain;
        logic [30:0] windup_limit;
        logic [15:0] brake_th;
        logic [15:0] accel_th;
    } t_cfg;

    // error, clamped integral and derivative of one sample
    typedef struct packed {
        logic [15:0] err;
        logic [31:0] integ;
        logic [16:0] diff;
    } t_s1;

    // pipeline movement between top level and stages
    typedef struct packed {
        logic adv;      // every stage moves one step
        logic accept;   // input transfer this cycle
        logic load_out; // a valid item moves into the output register
    } t_pipe_ctl;

endpackage

// ----- rtl/core/brake_light_pid_ramp.sv -----
// Brake light PID ramp: top level with configuration registers and pipeline control.
// Instantiates blpr_front, blpr_mac and blpr_ramp; depends on blpr_pkg.
//
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one signed z-axis sample,
//   used as the PID error. Output channel (o_out_valid / i_out_ready) returns
//   one result per sample: brightness level, braking flag and the saturated,
//   Q8.8-scaled control value.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register per
//   transfer; o_cfg_ready is always high. Unused indexes are dropped. Write
//   only while no sample is in flight.
//   One sample is taken every cycle unless the receiver stalls. The pipeline is
//   input stage, product stage, sum stage, scale/compare stage and output
//   register, all moving together; the input stage loads at the transfer edge
//   itself.
//   A stalled receiver freezes the whole pipeline; o_in_ready drops while the
//   output register holds an untaken result.
//   Reset clears integral and previous error, sets brightness to the idle
//   level 79, empties the pipeline and loads the default gains/thresholds.
module brake_light_pid_ramp import blpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_accel_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_brightness,
    output logic        o_braking,
    output logic [31:0] o_control_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic [3:0]       r_vld;
    logic             r_out_vld;
    t_pipe_ctl        w_ctl;
    t_s1              w_s1;
    logic [ACC_W-1:0] w_acc;

    assign w_ctl.adv      = !r_out_vld || i_out_ready;
    assign w_ctl.accept   = i_in_valid && w_ctl.adv;
    assign w_ctl.load_out = w_ctl.adv && r_vld[3];

    assign o_in_ready  = w_ctl.adv;
    assign o_out_valid = r_out_vld;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_ctl.adv) begin
            r_vld     <= {r_vld[2:0], w_ctl.accept};
            r_out_vld <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain       <= 16'sd256;
            r_cfg.i_gain       <= '0;
            r_cfg.d_gain       <= '0;
            r_cfg.windup_limit <= '0;
            r_cfg.brake_th     <= -16'sd900;
            r_cfg.accel_th     <= 16'sd900;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_P_GAIN:   r_cfg.p_gain       <= i_cfg_data[15:0];
                CFG_I_GAIN:   r_cfg.i_gain       <= i_cfg_data[15:0];
                CFG_D_GAIN:   r_cfg.d_gain       <= i_cfg_data[15:0];
                CFG_WINDUP:   r_cfg.windup_limit <= i_cfg_data[30:0];
                CFG_BRAKE_TH: r_cfg.brake_th     <= i_cfg_data[15:0];
                CFG_ACCEL_TH: r_cfg.accel_th     <= i_cfg_data[15:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    blpr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_accel_z      (i_accel_z),
        .i_windup_limit (r_cfg.windup_limit),
        .o_s1           (w_s1)
    );

    blpr_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_s1     (w_s1),
        .i_p_gain (r_cfg.p_gain),
        .i_i_gain (r_cfg.i_gain),
        .i_d_gain (r_cfg.d_gain),
        .o_acc    (w_acc)
    );

    blpr_ramp u_ramp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_acc           (w_acc),
        .i_brake_th      (r_cfg.brake_th),
        .i_accel_th      (r_cfg.accel_th),
        .o_brightness    (o_brightness),
        .o_braking       (o_braking),
        .o_control_value (o_control_value)
    );

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_brake_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_braking |-> o_brightness == BRIGHT_FULL)
        else $error("braking result without full brightness");

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_braking |-> o_brightness <= BRIGHT_MID)
        else $error("ramp level above mid level");

endmodule

// ----- rtl/core/blpr_front.sv -----
// Brake light PID ramp: integral with windup clamp and derivative.
// Holds the integral and previous error state; depends on blpr_pkg.
module blpr_front import blpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctl   i_ctl,
    input  logic [15:0] i_accel_z,
    input  logic [30:0] i_windup_limit,
    output t_s1         o_s1
);

    logic [31:0] r_integ;
    logic [15:0] r_prev;
    t_s1         r_s1;

    logic [32:0] w_sum;
    logic [32:0] w_lim_pos;
    logic [32:0] w_lim_neg;
    logic [31:0] n_integ;
    logic [16:0] w_diff;

    assign w_sum     = {r_integ[31], r_integ} + {{17{i_accel_z[15]}}, i_accel_z};
    assign w_lim_pos = {2'b00, i_windup_limit};
    assign w_lim_neg = 33'd0 - w_lim_pos;

    always_comb begin
        if ($signed(w_sum) < $signed(w_lim_neg)) begin
            n_integ = w_lim_neg[31:0];
        end else if ($signed(w_sum) > $signed(w_lim_pos)) begin
            n_integ = w_lim_pos[31:0];
        end else begin
            n_integ = w_sum[31:0];
        end
    end

    assign w_diff = {i_accel_z[15], i_accel_z} - {r_prev[15], r_prev};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_ctl.accept) begin
            r_integ <= n_integ;
            r_prev  <= i_accel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s1.err   <= i_accel_z;
            r_s1.integ <= n_integ;
            r_s1.diff  <= w_diff;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ----- rtl/core/blpr_mac.sv -----
// Brake light PID ramp: gain products, then their sum.
// Two register stages; depends on blpr_pkg.
module blpr_mac import blpr_pkg::*; (
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  t_s1              i_s1,
    input  logic [15:0]      i_p_gain,
    input  logic [15:0]      i_i_gain,
    input  logic [15:0]      i_d_gain,
    output logic [ACC_W-1:0] o_acc
);

    logic signed [31:0]      w_pe;
    logic signed [47:0]      w_ie;
    logic signed [32:0]      w_de;
    logic signed [31:0]      r_pe;
    logic signed [47:0]      r_ie;
    logic signed [32:0]      r_de;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] r_acc;

    assign w_pe = $signed(i_p_gain) * $signed(i_s1.err);
    assign w_ie = $signed(i_i_gain) * $signed(i_s1.integ);
    assign w_de = $signed(i_d_gain) * $signed(i_s1.diff);

    assign w_acc = ACC_W'(r_pe) + ACC_W'(r_ie) + ACC_W'(r_de);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_pe  <= w_pe;
            r_ie  <= w_ie;
            r_de  <= w_de;
            r_acc <= w_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/core/blpr_ramp.sv -----
// Brake light PID ramp: Q8.8 scaling, saturation, thresholds, brightness ramp.
// Holds the brightness level and the output register; depends on blpr_pkg.
module blpr_ramp import blpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [ACC_W-1:0] i_acc,
    input  logic [15:0]      i_brake_th,
    input  logic [15:0]      i_accel_th,
    output logic [10:0]      o_brightness,
    output logic             o_braking,
    output logic [31:0]      o_control_value
);

    logic [ACC_W-9:0] w_floor;
    logic [ACC_W-9:0] w_trunc;
    logic             w_ovf_hi;
    logic             w_ovf_lo;
    logic [31:0]      w_ctrl;

    logic [31:0]      r_ctrl4;
    logic             r_brake4;
    logic             r_above4;

    logic [10:0]      r_level;
    logic [10:0]      n_level;
    logic [10:0]      w_target;
    logic             r_braking;
    logic [31:0]      r_ctrl;

    // divide by 256 rounding toward zero: bump the floor for negative inexact values
    assign w_floor = i_acc[ACC_W-1:8];
    assign w_trunc = (i_acc[ACC_W-1] && (|i_acc[7:0])) ? w_floor + 1'b1 : w_floor;

    assign w_ovf_hi = !w_trunc[ACC_W-9] && (|w_trunc[ACC_W-10:31]);
    assign w_ovf_lo = w_trunc[ACC_W-9] && !(&w_trunc[ACC_W-10:31]);

    always_comb begin
        if (w_ovf_hi) begin
            w_ctrl = 32'h7FFF_FFFF;
        end else if (w_ovf_lo) begin
            w_ctrl = 32'h8000_0000;
        end else begin
            w_ctrl = w_trunc[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_ctrl4  <= w_ctrl;
            r_brake4 <= $signed(w_ctrl) < $signed({{16{i_brake_th[15]}}, i_brake_th});
            r_above4 <= $signed(w_ctrl) > $signed({{16{i_accel_th[15]}}, i_accel_th});
        end
    end

    assign w_target = r_above4 ? BRIGHT_MID : BRIGHT_IDLE;

    always_comb begin
        if (r_brake4) begin
            n_level = BRIGHT_FULL;
        end else if (r_level > BRIGHT_MID) begin
            n_level = BRIGHT_IDLE;
        end else if (r_level < w_target) begin
            n_level = r_level + 11'd1;
        end else if (r_level > w_target) begin
            n_level = r_level - 11'd1;
        end else begin
            n_level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= BRIGHT_IDLE;
        end else if (i_ctl.load_out) begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_braking <= r_brake4;
            r_ctrl    <= r_ctrl4;
        end
    end

    assign o_brightness    = r_level;
    assign o_braking       = r_braking;
    assign o_control_value = r_ctrl;

endmodule

// ----- sim/brake_light_pid_ramp_test.sv -----
// Self-checking testbench for brake_light_pid_ramp: PID control value, windup clamp and
// brightness ramp checked against a scoreboard with its own controller state.
// Depends on blpr_pkg and the brake_light_pid_ramp RTL.
module brake_light_pid_ramp_test;
    import blpr_pkg::*;

    localparam int     CYCLE_LIMIT = 300000;
    localparam longint CTL_MAX     = 64'sh7FFF_FFFF;
    localparam longint CTL_MIN     = -64'sh8000_0000;

    // indexes that decode to no register
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic [10:0] brightness;
        logic        braking;
        logic [31:0] control;
    } t_light_result;

    class light_scoreboard;
        longint        kp, ki, kd, windup, brake_th, accel_th;
        longint        integ, prev_err;
        logic [10:0]   level;
        t_light_result expected_q[$];
        int            errors;
        int            seen;

        function new();
            kp       = 256;
            ki       = 0;
            kd       = 0;
            windup   = 0;
            brake_th = -900;
            accel_th = 900;
            integ    = 0;
            prev_err = 0;
            level    = BRIGHT_IDLE;
            errors   = 0;
            seen     = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] data);
            case (idx)
                CFG_P_GAIN:   kp       = longint'($signed(data[15:0]));
                CFG_I_GAIN:   ki       = longint'($signed(data[15:0]));
                CFG_D_GAIN:   kd       = longint'($signed(data[15:0]));
                CFG_WINDUP:   windup   = longint'(data[30:0]);
                CFG_BRAKE_TH: brake_th = longint'($signed(data[15:0]));
                CFG_ACCEL_TH: accel_th = longint'($signed(data[15:0]));
                default: ;
            endcase
        endfunction

        // Advance the controller by one sample and queue the result it must give.
        function void note_sample(input logic [15:0] z);
            longint        e, s, d, acc, ctl;
            logic [10:0]   lvl, tgt;
            logic          brk;
            t_light_result r;
            e = longint'($signed(z));
            s = integ + e;
            if (s < -windup)
                s = -windup;
            else if (s > windup)
                s = windup;
            integ    = s;
            d        = e - prev_err;
            prev_err = e;
            acc = kp * e + ki * integ + kd * d;
            ctl = acc / 256;  // truncates toward zero
            if (ctl > CTL_MAX)
                ctl = CTL_MAX;
            else if (ctl < CTL_MIN)
                ctl = CTL_MIN;
            brk = (ctl < brake_th);
            lvl = level;
            if (brk) begin
                lvl = BRIGHT_FULL;
            end else begin
                tgt = (ctl > accel_th) ? BRIGHT_MID : BRIGHT_IDLE;
                if (lvl > BRIGHT_MID)
                    lvl = BRIGHT_IDLE;
                else if (lvl < tgt)
                    lvl = lvl + 11'd1;
                else if (lvl > tgt)
                    lvl = lvl - 11'd1;
            end
            level        = lvl;
            r.brightness = lvl;
            r.braking    = brk;
            r.control    = ctl[31:0];
            expected_q.push_back(r);
        endfunction

        task report(input string what, input longint got, input longint want);
            errors++;
            $display("result %0d: %s got %0d, want %0d", seen, what, got, want);
        endtask

        task check_result(input logic [10:0] b, input logic brk, input logic [31:0] c);
            t_light_result want;
            seen++;
            if (expected_q.size() == 0) begin
                report("unexpected transfer, brightness", b, 0);
                return;
            end
            want = expected_q.pop_front();
            if (b !== want.brightness)
                report("brightness", b, want.brightness);
            if (brk !== want.braking)
                report("braking", brk, want.braking);
            if (c !== want.control)
                report("control_value", longint'($signed(c)), longint'($signed(want.control)));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [15:0] i_accel_z       = 16'd0;
    logic        i_out_ready     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [2:0]  i_cfg_index     = 3'd0;
    logic [31:0] i_cfg_data      = 32'd0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [10:0] o_brightness;
    logic        o_braking;
    logic [31:0] o_control_value;
    logic        o_cfg_ready;

    light_scoreboard sb = new();
    int              cycles    = 0;
    int              max_gap   = 10;
    int              max_stall = 10;

    logic [15:0] reset_samples [0:10] = '{16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1,
                                          16'd900, 16'd901, -16'sd900, -16'sd901,
                                          16'h5555, 16'hAAAA};

    brake_light_pid_ramp u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_accel_z       (i_accel_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_brightness    (o_brightness),
        .o_braking       (o_braking),
        .o_control_value (o_control_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[brake_light_pid_ramp] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_brightness, o_braking, o_control_value);
    end

    // Receiver: stall a random number of cycles before each result transfer.
    initial begin : result_side
        int stall;
        forever begin
            stall = $urandom_range(max_stall, 0);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Keep valid high across back-to-back samples; lower it only for a gap.
    task automatic send_sample(input logic [15:0] z);
        int gap;
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_z  <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(z);
    endtask

    // Hold the sender until every queued result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    task automatic wait_idle();
        drain();
        repeat (6) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Write every register, junk in the unused upper bits, plus a dropped write.
    task automatic apply_setting(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [30:0] lim,
                                 input logic [15:0] brk_th, input logic [15:0] acc_th);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom();
        put_reg($urandom_range(1, 0) ? CFG_SPARE_A : CFG_SPARE_B, junk);
        junk = $urandom();
        put_reg(CFG_P_GAIN, {junk[31:16], kp});
        junk = $urandom();
        put_reg(CFG_I_GAIN, {junk[31:16], ki});
        junk = $urandom();
        put_reg(CFG_D_GAIN, {junk[31:16], kd});
        junk = $urandom();
        put_reg(CFG_WINDUP, {junk[31], lim});
        junk = $urandom();
        put_reg(CFG_BRAKE_TH, {junk[31:16], brk_th});
        junk = $urandom();
        put_reg(CFG_ACCEL_TH, {junk[31:16], acc_th});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        int          v;
        logic [31:0] raw;
        raw = $urandom();
        v   = int'($urandom_range(1200, 0)) - 600;
        case ($urandom_range(5, 0))
            0:       return raw[15:0];
            1:       return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
            default: return v[15:0];
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        int          v;
        logic [31:0] raw;
        raw = $urandom();
        v   = int'($urandom_range(6000, 0)) - 3000;
        case ($urandom_range(7, 0))
            0:       return raw[15:0];
            1:       return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
            default: return v[15:0];
        endcase
    endfunction

    function automatic logic [30:0] pick_windup();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(3, 0))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return raw[30:0];
            default: return 31'($urandom_range(100000, 0));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample(input logic [15:0] last);
        int          v;
        logic [31:0] raw;
        raw = $urandom();
        v   = int'($urandom_range(3000, 0)) - 1500;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return raw[15:0];
            4, 5, 6:    return v[15:0];
            7: begin
                case ($urandom_range(4, 0))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'hFFFF;
                    3:       return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default:    return last;
        endcase
    endfunction

    task automatic random_phase();
        int          count;
        logic [15:0] z;
        max_gap   = ($urandom_range(3, 0) == 0) ? 0 : 10;
        max_stall = ($urandom_range(3, 0) == 0) ? 0 : 10;
        apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_windup(),
                      pick_threshold(), pick_threshold());
        count = $urandom_range(50, 38);
        z     = 16'd0;
        repeat (count) begin
            z = pick_sample(z);
            send_sample(z);
            if ($urandom_range(39, 0) == 0)
                drain();
        end
    endtask

    initial begin : stimulus
        logic [15:0] z;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: unit proportional gain, no integral, default thresholds
        foreach (reset_samples[k])
            send_sample(reset_samples[k]);

        // extreme gains and thresholds, full-swing derivative
        apply_setting(16'h8000, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF, 16'h8000, 16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h0000);

        // tight clamp and small negative sums that must truncate toward zero
        apply_setting(16'd3, 16'd1, 16'hFFFF, 31'd5, 16'h7FFF, 16'h8000);
        send_sample(-16'sd100);
        send_sample(-16'sd1);
        send_sample(-16'sd3);
        send_sample(16'd7);
        send_sample(-16'sd7);
        send_sample(16'd100);

        repeat (4) random_phase();

        // Drive the integral past the point where the control value saturates high;
        // the level ramps all the way to mid and then holds there.
        max_gap   = 2;
        max_stall = 2;
        apply_setting(16'd0, 16'h7FFF, 16'd0, 31'h7FFF_FFFF, -16'sd900, 16'sd900);
        repeat (560) send_sample(16'($urandom_range(32767, 31000)));

        // flip the integral gain to hit the low saturation bound
        apply_setting(16'd0, 16'h8000, 16'd0, 31'h7FFF_FFFF, -16'sd900, 16'sd900);
        z = 16'd0;
        repeat (20) begin
            z = pick_sample(z);
            send_sample(z);
        end

        repeat (5) random_phase();

        wait_idle();
        if (sb.errors == 0)
            $display("[brake_light_pid_ramp] OK");
        else
            $display("[brake_light_pid_ramp] ERROR");
        $finish;
    end

endmodule
